// ----- rtl/jmsp_pkg.sv -----
package jmsp_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int SCAN_LEN_W     = 24;
    localparam int QDEPTH         = 4;
    localparam int QPTR_W         = $clog2(QDEPTH);
    localparam int QCNT_W         = $clog2(QDEPTH + 1);

    // region codes
    localparam logic [2:0] REG_HDR     = 3'd0;
    localparam logic [2:0] REG_Q0      = 3'd1;
    localparam logic [2:0] REG_Q1      = 3'd2;
    localparam logic [2:0] REG_SCAN    = 3'd3;
    localparam logic [2:0] REG_END     = 3'd4;
    localparam logic [2:0] REG_IGNORED = 3'd5;

    // status codes
    localparam logic [2:0] ST_RUN     = 3'd0;
    localparam logic [2:0] ST_EOI     = 3'd1;
    localparam logic [2:0] ST_FRAMING = 3'd2;
    localparam logic [2:0] ST_MARKER  = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;

    typedef struct packed {
        logic [7:0]            data;
        logic [2:0]            region;
        logic [2:0]            status;
        logic [SCAN_LEN_W-1:0] scan_len;
        logic                  last;
    } result_t;

endpackage

// ----- rtl/jmsp_step.sv -----
module jmsp_step #(
    parameter int COUNT_BITS = jmsp_pkg::COUNT_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic             frame_end,
    output jmsp_pkg::result_t res0,
    output jmsp_pkg::result_t res1,
    output logic [1:0]       res_n
);
    import jmsp_pkg::*;

    typedef enum logic [3:0] {
        PH_EXP_FF,
        PH_EXP_CODE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY,
        PH_SCAN,
        PH_DONE_EOI,
        PH_DONE_FRAMING,
        PH_DONE_MARKER
    } phase_t;

    localparam logic [7:0] MK_FF  = 8'hFF;
    localparam logic [7:0] MK_SOI = 8'hD8;
    localparam logic [7:0] MK_APP = 8'hE0;
    localparam logic [7:0] MK_DQT = 8'hDB;
    localparam logic [7:0] MK_DHT = 8'hC4;
    localparam logic [7:0] MK_SOF = 8'hC0;
    localparam logic [7:0] MK_SOS = 8'hDA;
    localparam logic [7:0] MK_EOI = 8'hD9;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    phase_t                phase_reg, phase_next;
    logic [7:0]            seg_type_reg, seg_type_next;
    logic [15:0]           len_reg, len_next;
    logic [15:0]           pos_reg, pos_next;
    logic [1:0]            tables_reg, tables_next;
    logic                  soi_reg, soi_next;
    logic                  held_reg, held_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [1:0]            tag_reg, tag_next;

    logic [COUNT_BITS-1:0] cnt_inc1, cnt_inc2;
    logic [15:0]           len_full;
    logic [15:0]           pos_inc;
    phase_t                end_phase;

    function automatic logic [SCAN_LEN_W-1:0] clip(input logic [COUNT_BITS-1:0] c);
        if (COUNT_BITS > SCAN_LEN_W && (c >> SCAN_LEN_W) != '0)
            return '1;
        return SCAN_LEN_W'(c);
    endfunction

    assign cnt_inc1  = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign cnt_inc2  = (cnt_inc1 == CNT_MAX) ? cnt_inc1 : cnt_inc1 + 1'b1;
    assign len_full  = {len_reg[15:8], data_byte};
    assign pos_inc   = pos_reg + 16'd1;
    assign end_phase = (seg_type_reg == MK_SOS) ? PH_SCAN : PH_EXP_FF;

    always_comb
    begin
        phase_next    = phase_reg;
        seg_type_next = seg_type_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        tables_next   = tables_reg;
        soi_next      = soi_reg;
        held_next     = held_reg;
        cnt_next      = cnt_reg;
        tag_next      = tag_reg;

        res0   = '{data: data_byte, region: REG_HDR, status: ST_RUN,
                   scan_len: clip(cnt_reg), last: 1'b0};
        res1   = res0;
        res_n  = 2'd1;

        unique case (phase_reg)
            PH_EXP_FF:
            begin
                if (data_byte == MK_FF)
                    phase_next = PH_EXP_CODE;
                else
                begin
                    phase_next  = PH_DONE_FRAMING;
                    res0.status = ST_FRAMING;
                end
            end
            PH_EXP_CODE:
            begin
                seg_type_next = data_byte;
                if (data_byte == MK_SOI)
                begin
                    soi_next   = 1'b1;
                    phase_next = PH_EXP_FF;
                end
                else if (data_byte == MK_APP || data_byte == MK_DHT ||
                         data_byte == MK_SOF || (data_byte == MK_SOS && soi_reg))
                begin
                    tag_next   = 2'd0;
                    phase_next = PH_LEN_HI;
                end
                else if (data_byte == MK_DQT)
                begin
                    if (soi_reg && tables_reg < 2'd2)
                    begin
                        tag_next    = tables_reg + 2'd1;
                        tables_next = tables_reg + 2'd1;
                    end
                    else
                        tag_next = 2'd0;
                    phase_next = PH_LEN_HI;
                end
                else
                begin
                    phase_next  = PH_DONE_MARKER;
                    res0.status = ST_MARKER;
                end
            end
            PH_LEN_HI:
            begin
                len_next   = {data_byte, 8'h00};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_next = len_full;
                pos_next = 16'd0;
                if (len_full < 16'd2)
                begin
                    phase_next  = PH_DONE_FRAMING;
                    res0.status = ST_FRAMING;
                end
                else if (len_full == 16'd2)
                    phase_next = end_phase;
                else
                    phase_next = PH_BODY;
            end
            PH_BODY:
            begin
                // skip the precision/id byte, tag the rest of a counted table
                if (tag_reg != 2'd0 && pos_reg != 16'd0)
                    res0.region = (tag_reg == 2'd1) ? REG_Q0 : REG_Q1;
                pos_next = pos_inc;
                if (pos_inc >= len_reg - 16'd2)
                    phase_next = end_phase;
            end
            PH_SCAN:
            begin
                if (held_reg)
                begin
                    held_next = 1'b0;
                    res0.data = MK_FF;
                    res_n     = 2'd2;
                    if (data_byte == 8'h00)
                    begin
                        cnt_next      = cnt_inc2;
                        res0.region   = REG_SCAN;
                        res0.scan_len = clip(cnt_inc1);
                        res1.region   = REG_SCAN;
                        res1.scan_len = clip(cnt_inc2);
                    end
                    else if (data_byte == MK_EOI)
                    begin
                        phase_next  = PH_DONE_EOI;
                        res0.region = REG_END;
                        res0.status = ST_EOI;
                        res1.region = REG_END;
                        res1.status = ST_EOI;
                    end
                    else
                    begin
                        phase_next  = PH_DONE_MARKER;
                        res0.status = ST_MARKER;
                        res1.status = ST_MARKER;
                    end
                end
                else if (data_byte == MK_FF)
                begin
                    // hold until the next byte decides
                    held_next = 1'b1;
                    res_n     = 2'd0;
                end
                else
                begin
                    cnt_next      = cnt_inc1;
                    res0.region   = REG_SCAN;
                    res0.scan_len = clip(cnt_inc1);
                end
            end
            PH_DONE_EOI:
            begin
                res0.region = REG_IGNORED;
                res0.status = ST_EOI;
            end
            PH_DONE_FRAMING:
            begin
                res0.region = REG_IGNORED;
                res0.status = ST_FRAMING;
            end
            PH_DONE_MARKER:
            begin
                res0.region = REG_IGNORED;
                res0.status = ST_MARKER;
            end
            default:
            begin
                res0.region = REG_IGNORED;
            end
        endcase

        if (frame_end)
        begin
            // release a held FF, mark running results truncated, restart
            if (held_next)
            begin
                if (res_n == 2'd0)
                begin
                    res0.data   = MK_FF;
                    res0.region = REG_HDR;
                    res0.status = ST_RUN;
                end
                else
                begin
                    res1.data   = MK_FF;
                    res1.region = REG_HDR;
                    res1.status = ST_RUN;
                    res1.scan_len = clip(cnt_next);
                end
                res_n = res_n + 2'd1;
            end
            if (res0.status == ST_RUN)
                res0.status = ST_TRUNC;
            if (res1.status == ST_RUN)
                res1.status = ST_TRUNC;
            phase_next    = PH_EXP_FF;
            seg_type_next = 8'h00;
            len_next      = 16'd0;
            pos_next      = 16'd0;
            tables_next   = 2'd0;
            soi_next      = 1'b0;
            held_next     = 1'b0;
            cnt_next      = '0;
            tag_next      = 2'd0;
        end

        res0.last = (res_n == 2'd1);
        res1.last = (res_n == 2'd2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_EXP_FF;
            seg_type_reg <= 8'h00;
            len_reg      <= 16'd0;
            pos_reg      <= 16'd0;
            tables_reg   <= 2'd0;
            soi_reg      <= 1'b0;
            held_reg     <= 1'b0;
            cnt_reg      <= '0;
            tag_reg      <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            seg_type_reg <= seg_type_next;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            tables_reg   <= tables_next;
            soi_reg      <= soi_next;
            held_reg     <= held_next;
            cnt_reg      <= cnt_next;
            tag_reg      <= tag_next;
        end
    end

endmodule

// ----- rtl/jmsp_outq.sv -----
module jmsp_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [1:0]       push_n,
    input  jmsp_pkg::result_t res0,
    input  jmsp_pkg::result_t res1,
    input  logic             pop,
    output jmsp_pkg::result_t head,
    output logic             not_empty,
    output logic             low_room
);
    import jmsp_pkg::*;

    result_t            q_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic [QPTR_W-1:0]  wr_ptr_p1;
    logic [1:0]         n_in;

    assign n_in      = push ? push_n : 2'd0;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;
    assign head      = q_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    // need room for two beats whatever the output side does
    assign low_room  = (count_reg > QCNT_W'(QDEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(n_in);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(n_in) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_in != 2'd0)
            q_reg[wr_ptr_reg] <= res0;
        if (n_in == 2'd2)
            q_reg[wr_ptr_p1] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/jpeg_marker_stream_parser.sv -----
// JPEG marker stream parser: takes one frame byte per beat and classifies it as
// header/marker, quantization table 0 or 1 payload, scan payload, end marker or
// ignored, with a running status and a saturating scan byte count. Each byte is
// parsed in the cycle it is accepted and its results go to a four-entry output
// queue draining one beat per cycle while out_stall is low. A byte usually gives
// one result, so the block sustains one byte per clock; an FF in the scan gives
// none and the byte after it gives two; input stalls while under two entries are
// free. Assert frame_end on the last byte of a frame; the parser restarts.
module jpeg_marker_stream_parser #(
    parameter int COUNT_BITS = jmsp_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      data_byte,
    input  logic                            frame_end,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      out_byte,
    output logic [2:0]                      region,
    output logic [2:0]                      status,
    output logic [jmsp_pkg::SCAN_LEN_W-1:0] scan_length,
    output logic                            run_last
);
    import jmsp_pkg::*;

    logic    accept;
    logic    pop;
    logic    low_room;
    logic    not_empty;
    logic [1:0] res_n;
    result_t res0, res1, head;

    assign in_stall = low_room;
    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    jmsp_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .res0      (res0),
        .res1      (res1),
        .res_n     (res_n)
    );

    jmsp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_n    (res_n),
        .res0      (res0),
        .res1      (res1),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .low_room  (low_room)
    );

    assign out_valid   = not_empty;
    assign out_byte    = head.data;
    assign region      = head.region;
    assign status      = head.status;
    assign scan_length = head.scan_len;
    assign run_last    = head.last;

    a_end_is_eoi: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && region == REG_END) |-> status == ST_EOI)
        else $error("end marker beat without EOI status");

    a_ignored_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && region == REG_IGNORED) |-> run_last)
        else $error("ignored byte produced more than one beat");

    a_scan_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && region == REG_SCAN) |-> (status == ST_RUN || status == ST_TRUNC))
        else $error("scan payload beat with a final status");

    a_two_results_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_n == 2'd2) |-> (!res0.last && res1.last))
        else $error("last flag misplaced on a two-beat byte");

endmodule
